// ----- hdl/assert_macros.svh -----
// assertion macros shared by the peer registry table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PRT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/prt_pkg.sv -----
// package with types and constants of the peer registry table
`default_nettype none

package prt_pkg;

  localparam int PEER_SLOTS = 16;
  localparam int CNT_W      = $clog2(PEER_SLOTS + 1);
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int SEQ_W      = 32;
  localparam int MODE_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_REG   = 2'd0,
    MODE_UNREG = 2'd1,
    MODE_LIST  = 2'd2,
    MODE_BAD   = 2'd3
  } prt_mode_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [SEQ_W-1:0]  seq;
  } prt_entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr_new;
    logic rotate;
    logic in_use;
  } prt_cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/prt_cell.sv -----
// one slot of the registry chain: entry storage, search token and pull-down
`default_nettype none

module prt_cell
  import prt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire prt_cell_ctl_t ctl,
  input  wire prt_entry_t    new_entry,
  input  wire prt_entry_t    nbr_entry,
  input  wire logic [SEQ_W-1:0] key,
  input  wire logic          tok_in,
  input  wire logic          found_in,
  output prt_entry_t         entry,
  output logic               tok_out,
  output logic               found_out
);

  logic match;

  assign match = ctl.in_use && (entry.seq == key);

  // token walks one slot per cycle; found marks a hit at or before this slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out   <= 1'b0;
      found_out <= 1'b0;
    end else begin
      tok_out   <= tok_in;
      found_out <= tok_in && (found_in || match);
    end
  end

  // rotation, or a hit at or below a slot, makes it pull its upper neighbor
  always_ff @(posedge clk) begin
    if (ctl.wr_new) begin
      entry <= new_entry;
    end else if (ctl.rotate || (tok_out && found_out)) begin
      entry <= nbr_entry;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/peer_registry_table_core.sv -----
// top level of the peer registry table: slot chain, sequencer and output register
//
// request channel: in_valid / in_stall with mode, peer_addr, peer_port, seq_key.
// result channel: out_valid / out_stall with status, assigned_seq, entry_addr,
// entry_port, entry_seq, entry_valid, last. a word moves when valid is high and
// stall is low at a rising edge of clk.
// one request is in flight at a time; in_stall is high from acceptance until
// its last result word has been loaded into the output register.
// register and invalid requests: one result word, loaded into the output
// register from the response state.
// unregister: the search token walks the slot chain, one slot a cycle, while
// the hit slot and the slots above it pull down; then one result word.
// list: the chain rotates PEER_SLOTS times through slot 0, giving one entry
// word per used slot, then a closing word.
// a stalled receiver freezes the rotation and holds the output word steady.
// rst (synchronous, active high) empties the table and sets the next sequence
// number to one; slot contents are not cleared and are read only once written.
`default_nettype none
`include "assert_macros.svh"

module peer_registry_table_core
  import prt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [ADDR_W-1:0] peer_addr,
  input  wire logic [PORT_W-1:0] peer_port,
  input  wire logic [SEQ_W-1:0]  seq_key,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [SEQ_W-1:0]       assigned_seq,
  output logic [ADDR_W-1:0]      entry_addr,
  output logic [PORT_W-1:0]      entry_port,
  output logic [SEQ_W-1:0]       entry_seq,
  output logic                   entry_valid,
  output logic                   last
);

  // one-hot sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_UNREG = 4'b0010,
    ST_LIST  = 4'b0100,
    ST_RESP  = 4'b1000
  } prt_state_t;

  prt_state_t        state;
  logic [CNT_W-1:0]  count;      // used slots
  logic [SEQ_W-1:0]  next_seq;
  logic [SEQ_W-1:0]  key;        // number to remove
  logic              tok_start;  // launches the search token into slot 0
  logic [CNT_W-1:0]  step;       // rotation step of a listing
  logic              resp_status;
  logic [SEQ_W-1:0]  resp_aseq;

  logic              accept;
  logic              out_free;
  logic              full;
  prt_entry_t        new_entry;
  prt_cell_ctl_t     cell_ctl   [PEER_SLOTS];
  prt_entry_t        cell_entry [PEER_SLOTS];
  logic              cell_tok   [PEER_SLOTS];
  logic              cell_found [PEER_SLOTS];

  // next output word
  logic              emit;
  logic              e_status;
  logic [SEQ_W-1:0]  e_aseq;
  prt_entry_t        e_entry;
  logic              e_valid;
  logic              e_last;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (count >= CNT_W'(PEER_SLOTS));

  assign new_entry.addr = peer_addr;
  assign new_entry.port = peer_port;
  assign new_entry.seq  = next_seq;

  // slot chain: slot i hands its entry to slot i-1, slot 0 wraps to the top
  for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_cell
    localparam int NB = (i + 1) % PEER_SLOTS;
    logic tok_in;
    logic found_in;

    if (i == 0) begin : g_head
      assign tok_in   = tok_start;
      assign found_in = 1'b0;
    end else begin : g_body
      assign tok_in   = cell_tok[i-1];
      assign found_in = cell_found[i-1];
    end

    assign cell_ctl[i].wr_new = accept && (mode == MODE_REG) && !full
                                && (count == CNT_W'(i));
    assign cell_ctl[i].rotate = (state == ST_LIST) && out_free;
    assign cell_ctl[i].in_use = (CNT_W'(i) < count);

    prt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl[i]),
      .new_entry (new_entry),
      .nbr_entry (cell_entry[NB]),
      .key       (key),
      .tok_in    (tok_in),
      .found_in  (found_in),
      .entry     (cell_entry[i]),
      .tok_out   (cell_tok[i]),
      .found_out (cell_found[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      next_seq  <= SEQ_W'(1);
      tok_start <= 1'b0;
    end else begin
      tok_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_REG: begin
                state <= ST_RESP;
                if (!full) begin
                  count    <= count + CNT_W'(1);
                  next_seq <= next_seq + SEQ_W'(1);
                end
              end
              MODE_UNREG: begin
                state     <= ST_UNREG;
                tok_start <= 1'b1;
              end
              MODE_LIST: begin
                state <= ST_LIST;
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_UNREG: begin
          // token leaving the top slot ends the search and the pull-down
          if (cell_tok[PEER_SLOTS-1]) begin
            state <= ST_RESP;
            if (cell_found[PEER_SLOTS-1]) begin
              count <= count - CNT_W'(1);
            end
          end
        end
        ST_LIST: begin
          if (out_free && (step == CNT_W'(PEER_SLOTS - 1))) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request data and pending response word
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step <= '0;
        if (accept) begin
          key <= seq_key;
          case (mode)
            MODE_REG: begin
              resp_status <= full;
              resp_aseq   <= full ? '0 : next_seq;
            end
            MODE_UNREG, MODE_LIST: begin
              resp_status <= 1'b0;
              resp_aseq   <= '0;
            end
            default: begin
              resp_status <= 1'b1;
              resp_aseq   <= '0;
            end
          endcase
        end
      end
      ST_UNREG: begin
        if (cell_tok[PEER_SLOTS-1]) begin
          resp_status <= !cell_found[PEER_SLOTS-1];
        end
      end
      ST_LIST: begin
        if (out_free) begin
          step <= step + CNT_W'(1);
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // output word select: slot 0 during a listing, pending response at the end
  always_comb begin
    emit     = 1'b0;
    e_status = 1'b0;
    e_aseq   = '0;
    e_entry  = '0;
    e_valid  = 1'b0;
    e_last   = 1'b0;
    case (state)
      ST_LIST: begin
        if (step < count) begin
          emit    = 1'b1;
          e_entry = cell_entry[0];
          e_valid = 1'b1;
        end
      end
      ST_RESP: begin
        emit     = 1'b1;
        e_status = resp_status;
        e_aseq   = resp_aseq;
        e_last   = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      status       <= e_status;
      assigned_seq <= e_aseq;
      entry_addr   <= e_entry.addr;
      entry_port   <= e_entry.port;
      entry_seq    <= e_entry.seq;
      entry_valid  <= e_valid;
      last         <= e_last;
    end
  end

  // checks
  `PRT_ASSERT(a_count_range, count <= CNT_W'(PEER_SLOTS), "used count beyond table size")
  `PRT_ASSERT(a_accept_busy, accept |=> (state != ST_IDLE), "request taken but sequencer idle")
  `PRT_ASSERT_NEVER(a_entry_last, out_valid && entry_valid && last, "listed entry marked last")
  `PRT_ASSERT(a_token_unreg, cell_tok[PEER_SLOTS-1] |-> (state == ST_UNREG), "stray search token")

endmodule

`default_nettype wire
